/* rtl/mnlp_pkg.sv */
// Shared constants for the macro number list parser.
package mnlp_pkg;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 27;
  localparam int CNT_W   = 16;
  localparam int ROW_W   = 5;
  localparam int SLOT_W  = 6;
  localparam int MC_W    = 6;

  localparam logic [1:0] KIND_NUMBER = 2'd0;
  localparam logic [1:0] KIND_ERROR  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [1:0] ERR_TOO_MANY_DIGITS = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED_CHAR = 2'd1;
  localparam logic [1:0] ERR_OUT_OF_RANGE    = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

endpackage

/* rtl/mnlp_if.sv */
// Request channels of the macro number list parser: text bytes in, results out.
interface mnlp_in_if;
  logic                           valid;
  logic                           ready;
  logic [mnlp_pkg::CHAR_W-1:0]    char_code;
  logic                           end_of_file;

  modport source (output valid, output char_code, output end_of_file, input ready);
  modport sink   (input valid, input char_code, input end_of_file, output ready);
endinterface

interface mnlp_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [mnlp_pkg::ROW_W-1:0]     row;
  logic [mnlp_pkg::SLOT_W-1:0]    key_slot;
  logic [mnlp_pkg::VALUE_W-1:0]   value;
  logic [1:0]                     error_code;
  logic [mnlp_pkg::CNT_W-1:0]     line_number;
  logic [mnlp_pkg::CNT_W-1:0]     column_number;
  logic [mnlp_pkg::MC_W-1:0]      macro_count;

  modport source (output valid, output kind, output row, output key_slot, output value,
                  output error_code, output line_number, output column_number,
                  output macro_count, input ready);
  modport sink   (input valid, input kind, input row, input key_slot, input value,
                  input error_code, input line_number, input column_number,
                  input macro_count, output ready);
endinterface

/* rtl/macro_number_list_parser_top.sv */
// Macro number list parser: decimal key-code text to (row, slot, value) results.
// One text byte is taken per clock. Each request is decoded in a single
// combinational step against the parser state and lands in the result register
// on the same edge, so a result is presented in the cycle after its byte is taken.
// A byte is accepted whenever the result register is empty or being drained,
// giving a sustained rate of one byte per cycle; only a stalled result slows it.
// At most one result per byte. After an error the parser ignores bytes until
// end_of_file, which always returns the done result and resets the parser.
module macro_number_list_parser_top #(
  parameter int MAX_DIGITS = 8,
  parameter int MAX_ROWS   = 32,
  parameter int MAX_SLOTS  = 64
) (
  input  logic        clk,
  input  logic        rst,
  mnlp_in_if.sink     in_ch,
  mnlp_out_if.source  out_ch
);

  localparam int DW = $clog2(MAX_DIGITS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int SW = $clog2(MAX_SLOTS + 1);

  // parser state
  logic                          gap_phase, gap_phase_next;
  logic                          halted, halted_next;
  logic [DW-1:0]                 digit_count, digit_count_next;
  logic [mnlp_pkg::VALUE_W-1:0]  accumulator, accumulator_next;
  logic [RW-1:0]                 row_index, row_index_next;
  logic [SW-1:0]                 slot_index, slot_index_next;
  logic [mnlp_pkg::CNT_W-1:0]    line_counter, line_counter_next;
  logic [mnlp_pkg::CNT_W-1:0]    column_counter, column_counter_next;
  logic [RW-1:0]                 rows_used, rows_used_next;

  // result of the current request
  logic                          res_valid;
  logic [1:0]                    res_kind;
  logic [1:0]                    res_error;
  logic                          res_stored;
  logic [31:0]                   row_wide, slot_wide, mc_wide;

  logic                          accept;
  logic                          is_digit, is_nl, is_comma, is_blank;
  logic [mnlp_pkg::VALUE_W-1:0]  digit_val;
  logic [mnlp_pkg::CNT_W-1:0]    column_inc;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_digit  = (in_ch.char_code >= mnlp_pkg::CH_ZERO) &&
                     (in_ch.char_code <= mnlp_pkg::CH_NINE);
  assign is_nl     = (in_ch.char_code == mnlp_pkg::CH_NEWLINE) ||
                     (in_ch.char_code == mnlp_pkg::CH_CR);
  assign is_comma  = in_ch.char_code == mnlp_pkg::CH_COMMA;
  assign is_blank  = (in_ch.char_code == mnlp_pkg::CH_SPACE) ||
                     (in_ch.char_code == mnlp_pkg::CH_TAB);
  assign digit_val = mnlp_pkg::VALUE_W'(in_ch.char_code[3:0]);
  assign column_inc = (column_counter == mnlp_pkg::CNT_MAX) ? column_counter
                                                             : column_counter + 1'b1;

  always_comb begin
    logic go;
    logic fail;
    go                  = 1'b1;
    fail                = 1'b0;
    res_stored          = 1'b0;
    res_error           = mnlp_pkg::ERR_TOO_MANY_DIGITS;
    res_valid           = 1'b0;
    res_kind            = mnlp_pkg::KIND_NUMBER;
    gap_phase_next      = gap_phase;
    halted_next         = halted;
    digit_count_next    = digit_count;
    accumulator_next    = accumulator;
    row_index_next      = row_index;
    slot_index_next     = slot_index;
    line_counter_next   = line_counter;
    column_counter_next = column_counter;
    rows_used_next      = rows_used;

    if (in_ch.end_of_file) begin
      res_valid           = 1'b1;
      res_kind            = mnlp_pkg::KIND_DONE;
      gap_phase_next      = 1'b0;
      halted_next         = 1'b0;
      digit_count_next    = '0;
      accumulator_next    = '0;
      row_index_next      = '0;
      slot_index_next     = '0;
      line_counter_next   = '0;
      column_counter_next = '0;
      rows_used_next      = '0;
    end else if (!halted) begin
      if (!gap_phase) begin
        if (is_digit) begin
          go = 1'b0;
          if (digit_count >= DW'(MAX_DIGITS)) begin
            fail      = 1'b1;
            res_error = mnlp_pkg::ERR_TOO_MANY_DIGITS;
          end else begin
            accumulator_next    = (accumulator << 3) + (accumulator << 1) + digit_val;
            digit_count_next    = digit_count + 1'b1;
            column_counter_next = column_inc;
          end
        end else begin
          if (digit_count != '0) begin
            if (row_index >= RW'(MAX_ROWS) || slot_index >= SW'(MAX_SLOTS)) begin
              go        = 1'b0;
              fail      = 1'b1;
              res_error = mnlp_pkg::ERR_OUT_OF_RANGE;
            end else begin
              res_stored       = 1'b1;
              slot_index_next  = slot_index + 1'b1;
              rows_used_next   = row_index + 1'b1;
              accumulator_next = '0;
              digit_count_next = '0;
            end
          end
          if (go) begin
            if (is_nl) begin
              slot_index_next = '0;
              if (row_index < RW'(MAX_ROWS)) row_index_next = row_index + 1'b1;
            end
            gap_phase_next = 1'b1;
            // a comma that closes a number is swallowed here
            if (is_comma) go = 1'b0;
          end
        end
      end

      if (go) begin
        if (is_nl) begin
          column_counter_next = '0;
          line_counter_next   = (line_counter == mnlp_pkg::CNT_MAX) ? line_counter
                                                                     : line_counter + 1'b1;
        end else if (is_blank) begin
          column_counter_next = column_inc;
        end else if (is_digit) begin
          gap_phase_next      = 1'b0;
          accumulator_next    = digit_val;
          digit_count_next    = DW'(1);
          column_counter_next = column_inc;
        end else begin
          fail      = 1'b1;
          res_error = mnlp_pkg::ERR_UNEXPECTED_CHAR;
        end
      end

      // an error wins over a number closed by the same byte
      if (fail) begin
        halted_next = 1'b1;
        res_valid   = 1'b1;
        res_kind    = mnlp_pkg::KIND_ERROR;
      end else if (res_stored) begin
        res_valid = 1'b1;
        res_kind  = mnlp_pkg::KIND_NUMBER;
      end
    end
  end

  assign row_wide  = 32'(row_index);
  assign slot_wide = 32'(slot_index);
  assign mc_wide   = 32'(rows_used);

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_phase      <= 1'b0;
      halted         <= 1'b0;
      digit_count    <= '0;
      accumulator    <= '0;
      row_index      <= '0;
      slot_index     <= '0;
      line_counter   <= '0;
      column_counter <= '0;
      rows_used      <= '0;
      out_ch.valid   <= 1'b0;
    end else begin
      if (accept) begin
        gap_phase      <= gap_phase_next;
        halted         <= halted_next;
        digit_count    <= digit_count_next;
        accumulator    <= accumulator_next;
        row_index      <= row_index_next;
        slot_index     <= slot_index_next;
        line_counter   <= line_counter_next;
        column_counter <= column_counter_next;
        rows_used      <= rows_used_next;
        out_ch.valid   <= res_valid;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // result payload, loaded only when a result is produced
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_ch.kind          <= res_kind;
      out_ch.row           <= '0;
      out_ch.key_slot      <= '0;
      out_ch.value         <= '0;
      out_ch.error_code    <= '0;
      out_ch.line_number   <= '0;
      out_ch.column_number <= '0;
      out_ch.macro_count   <= '0;
      unique case (res_kind)
        mnlp_pkg::KIND_NUMBER: begin
          out_ch.row      <= row_wide[mnlp_pkg::ROW_W-1:0];
          out_ch.key_slot <= slot_wide[mnlp_pkg::SLOT_W-1:0];
          out_ch.value    <= accumulator;
        end
        mnlp_pkg::KIND_ERROR: begin
          out_ch.error_code    <= res_error;
          out_ch.line_number   <= line_counter;
          out_ch.column_number <= column_counter;
        end
        default: begin
          out_ch.macro_count <= mc_wide[mnlp_pkg::MC_W-1:0];
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // end of text always produces the done result right behind it
  a_eof_done: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.end_of_file |=> out_ch.valid && out_ch.kind == mnlp_pkg::KIND_DONE)
    else $error("end of text did not produce a done result");

  // a halted parser drops plain bytes silently
  a_halted_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && halted && !in_ch.end_of_file |=> !out_ch.valid)
    else $error("halted parser produced a result");

  // after an error only end of text may restart the parser
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid && res_kind == mnlp_pkg::KIND_ERROR |=> halted)
    else $error("error did not halt the parser");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.kind == mnlp_pkg::KIND_ERROR |->
      out_ch.error_code == mnlp_pkg::ERR_TOO_MANY_DIGITS ||
      out_ch.error_code == mnlp_pkg::ERR_UNEXPECTED_CHAR ||
      out_ch.error_code == mnlp_pkg::ERR_OUT_OF_RANGE)
    else $error("undefined error code on result");
`endif

endmodule
